[rtl/ltfc_pkg.sv]
// ----------------------------------------------------------------------------
// ltfc_pkg: shared types and constants of the loop transport frame counter
// register indexes, operation codes, command kinds and divider status
// ----------------------------------------------------------------------------
package ltfc_pkg;

   // default frame counter width
   localparam int FRAME_BITS_DEFAULT = 26;

   // beat number width and saturation value
   localparam int BEAT_BITS = 10;
   localparam logic [BEAT_BITS-1:0] BEAT_MAX = 10'd1023;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOOP_FRAMES     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BEAT_FRAMES     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BAR_FRAMES      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_QUANTUM_FRAMES  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_QUANTIZE_ENABLE = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TRANSPORT_MODE  = 3'd5;

   // transport modes
   localparam int MODE_BITS = 2;
   localparam logic [MODE_BITS-1:0] MODE_STOPPED = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_RUNNING = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_WAITING = 2'd2;

   // input operation codes
   localparam logic OP_ADVANCE = 1'b0;
   localparam logic OP_REWIND  = 1'b1;

   // command kinds after classification
   localparam int KIND_BITS = 2;
   localparam logic [KIND_BITS-1:0] KIND_REWIND = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_PLAY   = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_WAIT   = 2'd2;

   // command queue depth
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QCNT_BITS   = 2;

   // divider status toward the sequencer
   typedef struct packed {
      logic done;
      logic rem_zero;
      logic quo_over;
   } div_status_type;

endpackage

[rtl/ltfc_front.sv]
// ----------------------------------------------------------------------------
// ltfc_front: input acceptance and command classification
// decodes each transfer into a command kind and pushes it into the queue
// ----------------------------------------------------------------------------
module ltfc_front #(
   parameter int FRAME_BITS = ltfc_pkg::FRAME_BITS_DEFAULT
) (
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic [FRAME_BITS-1:0]                 req_frame_count,
   input  logic [ltfc_pkg::MODE_BITS-1:0]        transport_mode,
   input  logic                                  queue_full,
   output logic                                  push,
   output logic [ltfc_pkg::KIND_BITS-1:0]        push_kind,
   output logic [FRAME_BITS-1:0]                 push_amount
);

   // stall while the queue has no room
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // classify: rewind, advance of the play position or of the wait counter
   always_comb begin
      if (req_opcode == ltfc_pkg::OP_REWIND) begin
         push_kind = ltfc_pkg::KIND_REWIND;
      end else if (transport_mode == ltfc_pkg::MODE_WAITING) begin
         push_kind = ltfc_pkg::KIND_WAIT;
      end else begin
         push_kind = ltfc_pkg::KIND_PLAY;
      end
   end

   assign push_amount = req_frame_count;

endmodule

[rtl/ltfc_queue.sv]
// ----------------------------------------------------------------------------
// ltfc_queue: short command queue between front and back
// two entries, registered storage, separate read and write pointers
// ----------------------------------------------------------------------------
module ltfc_queue #(
   parameter int WIDTH = ltfc_pkg::KIND_BITS + ltfc_pkg::FRAME_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   logic [WIDTH-1:0]                    entry_ff [ltfc_pkg::QUEUE_DEPTH];
   logic [ltfc_pkg::QPTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [ltfc_pkg::QPTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [ltfc_pkg::QCNT_BITS-1:0]      count_ff, count_in;

   assign full      = (count_ff == ltfc_pkg::QCNT_BITS'(ltfc_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/ltfc_divider.sv]
// ----------------------------------------------------------------------------
// ltfc_divider: shared restoring divider
// two quotient bits per cycle, quotient and remainder held until next start
// ----------------------------------------------------------------------------
module ltfc_divider #(
   parameter int FRAME_BITS = ltfc_pkg::FRAME_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [FRAME_BITS:0]                dividend,
   input  logic [FRAME_BITS-1:0]              divisor,
   output ltfc_pkg::div_status_type           status,
   output logic [FRAME_BITS-1:0]              remainder,
   output logic [ltfc_pkg::BEAT_BITS-1:0]     quotient
);

   localparam int DIV_BITS = 2 * ((FRAME_BITS + 2) / 2);
   localparam int STEPS    = DIV_BITS / 2;
   localparam int CNT_BITS = $clog2(STEPS);

   logic [FRAME_BITS-1:0] div_ff, div_in;
   logic [FRAME_BITS:0]   rem_ff, rem_in;
   logic [DIV_BITS-1:0]   quo_ff, quo_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [FRAME_BITS:0]   rem_step;
   logic [DIV_BITS-1:0]   quo_step;
   logic [FRAME_BITS:0]   trial;

   // two dependent compare and subtract steps
   always_comb begin
      rem_step = rem_ff;
      quo_step = quo_ff;
      trial    = '0;
      for (int i = 0; i < 2; i++) begin
         trial = {rem_step[FRAME_BITS-1:0], quo_step[DIV_BITS-1]};
         if (trial >= {1'b0, div_ff}) begin
            rem_step = trial - {1'b0, div_ff};
            quo_step = {quo_step[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_step = trial;
            quo_step = {quo_step[DIV_BITS-2:0], 1'b0};
         end
      end
   end

   // iteration control
   always_comb begin
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = DIV_BITS'(dividend);
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = rem_step;
         quo_in = quo_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign remainder       = rem_ff[FRAME_BITS-1:0];
   assign quotient        = quo_ff[ltfc_pkg::BEAT_BITS-1:0];
   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);
   assign status.quo_over = |quo_ff[DIV_BITS-1:ltfc_pkg::BEAT_BITS];

endmodule

[rtl/ltfc_back.sv]
// ----------------------------------------------------------------------------
// ltfc_back: command execution sequencer
// holds the counters, runs the divisions in turn and fills the result register
// ----------------------------------------------------------------------------
module ltfc_back #(
   parameter int FRAME_BITS = ltfc_pkg::FRAME_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // command queue side
   input  logic                               cmd_valid,
   input  logic [ltfc_pkg::KIND_BITS-1:0]     cmd_kind,
   input  logic [FRAME_BITS-1:0]              cmd_amount,
   output logic                               cmd_pop,
   // configuration
   input  logic [FRAME_BITS-1:0]              loop_frames,
   input  logic [FRAME_BITS-1:0]              beat_frames,
   input  logic [FRAME_BITS-1:0]              bar_frames,
   input  logic [FRAME_BITS-1:0]              quantum_frames,
   input  logic                               quantize_enable,
   // divider side
   output logic                               div_start,
   output logic [FRAME_BITS:0]                div_dividend,
   output logic [FRAME_BITS-1:0]              div_divisor,
   input  ltfc_pkg::div_status_type           div_status,
   input  logic [FRAME_BITS-1:0]              div_remainder,
   input  logic [ltfc_pkg::BEAT_BITS-1:0]     div_quotient,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [FRAME_BITS-1:0]              rsp_play_frame,
   output logic [ltfc_pkg::BEAT_BITS-1:0]     rsp_beat_index,
   output logic [FRAME_BITS-1:0]              rsp_wait_frame,
   output logic                               rsp_on_bar,
   output logic                               rsp_on_beat,
   output logic                               rsp_on_first_beat,
   output logic                               rsp_quantum_passed
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WRAP  = 3'd1;
   localparam logic [2:0] ST_BEAT  = 3'd2;
   localparam logic [2:0] ST_BAR   = 3'd3;
   localparam logic [2:0] ST_QUANT = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]                       state_ff, state_in;
   logic                             go_ff, go_in;
   logic [ltfc_pkg::KIND_BITS-1:0]   kind_ff, kind_in;
   logic [FRAME_BITS-1:0]            amount_ff, amount_in;
   logic [FRAME_BITS-1:0]            play_ff, play_in;
   logic [ltfc_pkg::BEAT_BITS-1:0]   beat_ff, beat_in;
   logic [FRAME_BITS-1:0]            wait_ff, wait_in;
   logic                             bar_hit_ff, bar_hit_in;
   logic                             beat_hit_ff, beat_hit_in;
   logic                             quant_hit_ff, quant_hit_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [FRAME_BITS-1:0]            loop_nz, beat_nz, bar_nz, quantum_nz;
   logic [FRAME_BITS-1:0]            active;
   logic                             waiting;

   // a zero length acts as one
   assign loop_nz    = (loop_frames == '0)    ? FRAME_BITS'(1) : loop_frames;
   assign beat_nz    = (beat_frames == '0)    ? FRAME_BITS'(1) : beat_frames;
   assign bar_nz     = (bar_frames == '0)     ? FRAME_BITS'(1) : bar_frames;
   assign quantum_nz = (quantum_frames == '0) ? FRAME_BITS'(1) : quantum_frames;

   assign waiting = (kind_ff == ltfc_pkg::KIND_WAIT);
   assign active  = waiting ? wait_ff : play_ff;

   // divider operand selection by phase
   always_comb begin
      case (state_ff)
         ST_WRAP: begin
            div_dividend = {1'b0, active} + {1'b0, amount_ff};
            div_divisor  = loop_nz;
         end
         ST_BEAT: begin
            div_dividend = {1'b0, active};
            div_divisor  = beat_nz;
         end
         ST_BAR: begin
            div_dividend = {1'b0, play_ff};
            div_divisor  = bar_nz;
         end
         default: begin
            div_dividend = {1'b0, play_ff};
            div_divisor  = quantum_nz;
         end
      endcase
   end

   assign div_start = go_ff;
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid && !rsp_valid_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      go_in        = 1'b0;
      kind_in      = kind_ff;
      amount_in    = amount_ff;
      play_in      = play_ff;
      beat_in      = beat_ff;
      wait_in      = wait_ff;
      bar_hit_in   = bar_hit_ff;
      beat_hit_in  = beat_hit_ff;
      quant_hit_in = quant_hit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               kind_in   = cmd_kind;
               amount_in = cmd_amount;
               if (cmd_kind == ltfc_pkg::KIND_REWIND) begin
                  play_in      = '0;
                  beat_in      = '0;
                  wait_in      = '0;
                  bar_hit_in   = 1'b0;
                  beat_hit_in  = 1'b1;
                  quant_hit_in = quantize_enable;
                  state_in     = ST_EMIT;
               end else begin
                  state_in = ST_WRAP;
                  go_in    = 1'b1;
               end
            end
         end
         ST_WRAP: begin
            if (div_status.done) begin
               if (waiting) begin
                  wait_in = div_remainder;
               end else begin
                  play_in = div_remainder;
               end
               state_in = ST_BEAT;
               go_in    = 1'b1;
            end
         end
         ST_BEAT: begin
            if (div_status.done) begin
               beat_hit_in = div_status.rem_zero;
               if (waiting) begin
                  bar_hit_in = 1'b0;
                  if (quantize_enable) begin
                     state_in = ST_QUANT;
                     go_in    = 1'b1;
                  end else begin
                     quant_hit_in = 1'b0;
                     state_in     = ST_EMIT;
                  end
               end else begin
                  beat_in  = div_status.quo_over ? ltfc_pkg::BEAT_MAX : div_quotient;
                  state_in = ST_BAR;
                  go_in    = 1'b1;
               end
            end
         end
         ST_BAR: begin
            if (div_status.done) begin
               bar_hit_in = div_status.rem_zero && (play_ff != '0);
               if (quantize_enable) begin
                  state_in = ST_QUANT;
                  go_in    = 1'b1;
               end else begin
                  quant_hit_in = 1'b0;
                  state_in     = ST_EMIT;
               end
            end
         end
         ST_QUANT: begin
            if (div_status.done) begin
               quant_hit_in = div_status.rem_zero;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_EMIT) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         play_ff      <= '0;
         beat_ff      <= '0;
         wait_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
         play_ff      <= play_in;
         beat_ff      <= beat_in;
         wait_ff      <= wait_in;
      end
   end

   // command payload and flags
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      amount_ff    <= amount_in;
      bar_hit_ff   <= bar_hit_in;
      beat_hit_ff  <= beat_hit_in;
      quant_hit_ff <= quant_hit_in;
   end

   // result payload, loaded once per command
   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT) begin
         rsp_play_frame     <= play_ff;
         rsp_beat_index     <= beat_ff;
         rsp_wait_frame     <= wait_ff;
         rsp_on_bar         <= bar_hit_ff;
         rsp_on_beat        <= beat_hit_ff;
         rsp_on_first_beat  <= (play_ff == '0);
         rsp_quantum_passed <= quant_hit_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/loop_transport_frame_counter.sv]
// ----------------------------------------------------------------------------
// loop_transport_frame_counter: musical loop transport counter
// advances play or wait position modulo the loop, tracks the beat number and
// reports bar, beat, first-beat and quantum flags for every transfer
//
//   channel   ports                          direction
//   req       req_valid/req_stall, payload   in   opcode, frame_count
//   rsp       rsp_valid/rsp_stall, payload   out  counters and flags
//   csr       csr_wen, csr_index, csr_wdata  in   register writes
//
// an advance runs wrap, beat, bar and quantum divisions in turn on the shared
// divider; waiting mode skips the bar division, a disabled quantizer the
// quantum one. a rewind runs no division and goes through the emit state to
// the result register. one command executes at a time; a two-entry queue keeps
// accepting while a result waits, and a stalled result holds the back end.
// reset clears the counters, sets the length registers to one, turns the
// quantizer off and puts the transport in stopped mode.
// ----------------------------------------------------------------------------
module loop_transport_frame_counter #(
   parameter int FRAME_BITS = ltfc_pkg::FRAME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration write port
   input  logic                                csr_wen,
   input  logic [ltfc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [FRAME_BITS-1:0]               csr_wdata,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [FRAME_BITS-1:0]               req_frame_count,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [FRAME_BITS-1:0]               rsp_play_frame,
   output logic [ltfc_pkg::BEAT_BITS-1:0]      rsp_beat_index,
   output logic [FRAME_BITS-1:0]               rsp_wait_frame,
   output logic                                rsp_on_bar,
   output logic                                rsp_on_beat,
   output logic                                rsp_on_first_beat,
   output logic                                rsp_quantum_passed
);

   localparam int CMD_BITS = ltfc_pkg::KIND_BITS + FRAME_BITS;

   logic [FRAME_BITS-1:0]              loop_ff, loop_in;
   logic [FRAME_BITS-1:0]              beat_ff, beat_in;
   logic [FRAME_BITS-1:0]              bar_ff, bar_in;
   logic [FRAME_BITS-1:0]              quantum_ff, quantum_in;
   logic                               quant_en_ff, quant_en_in;
   logic [ltfc_pkg::MODE_BITS-1:0]     mode_ff, mode_in;

   logic                               queue_full;
   logic                               push;
   logic [ltfc_pkg::KIND_BITS-1:0]     push_kind;
   logic [FRAME_BITS-1:0]              push_amount;
   logic                               pop;
   logic [CMD_BITS-1:0]                pop_data;
   logic                               cmd_valid;

   logic                               div_start;
   logic [FRAME_BITS:0]                div_dividend;
   logic [FRAME_BITS-1:0]              div_divisor;
   ltfc_pkg::div_status_type           div_status;
   logic [FRAME_BITS-1:0]              div_remainder;
   logic [ltfc_pkg::BEAT_BITS-1:0]     div_quotient;

   // configuration register writes
   always_comb begin
      loop_in     = loop_ff;
      beat_in     = beat_ff;
      bar_in      = bar_ff;
      quantum_in  = quantum_ff;
      quant_en_in = quant_en_ff;
      mode_in     = mode_ff;
      if (csr_wen) begin
         case (csr_index)
            ltfc_pkg::REG_LOOP_FRAMES:     loop_in     = csr_wdata;
            ltfc_pkg::REG_BEAT_FRAMES:     beat_in     = csr_wdata;
            ltfc_pkg::REG_BAR_FRAMES:      bar_in      = csr_wdata;
            ltfc_pkg::REG_QUANTUM_FRAMES:  quantum_in  = csr_wdata;
            ltfc_pkg::REG_QUANTIZE_ENABLE: quant_en_in = csr_wdata[0];
            ltfc_pkg::REG_TRANSPORT_MODE:  mode_in     = csr_wdata[ltfc_pkg::MODE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_ff     <= FRAME_BITS'(1);
         beat_ff     <= FRAME_BITS'(1);
         bar_ff      <= FRAME_BITS'(1);
         quantum_ff  <= FRAME_BITS'(1);
         quant_en_ff <= 1'b0;
         mode_ff     <= ltfc_pkg::MODE_STOPPED;
      end else begin
         loop_ff     <= loop_in;
         beat_ff     <= beat_in;
         bar_ff      <= bar_in;
         quantum_ff  <= quantum_in;
         quant_en_ff <= quant_en_in;
         mode_ff     <= mode_in;
      end
   end

   // accept and classify
   ltfc_front #(
      .FRAME_BITS (FRAME_BITS)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_frame_count (req_frame_count),
      .transport_mode  (mode_ff),
      .queue_full      (queue_full),
      .push            (push),
      .push_kind       (push_kind),
      .push_amount     (push_amount)
   );

   // command queue
   ltfc_queue #(
      .WIDTH (CMD_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_kind, push_amount}),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (cmd_valid)
   );

   // execution sequencer
   ltfc_back #(
      .FRAME_BITS (FRAME_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (cmd_valid),
      .cmd_kind           (pop_data[CMD_BITS-1:FRAME_BITS]),
      .cmd_amount         (pop_data[FRAME_BITS-1:0]),
      .cmd_pop            (pop),
      .loop_frames        (loop_ff),
      .beat_frames        (beat_ff),
      .bar_frames         (bar_ff),
      .quantum_frames     (quantum_ff),
      .quantize_enable    (quant_en_ff),
      .div_start          (div_start),
      .div_dividend       (div_dividend),
      .div_divisor        (div_divisor),
      .div_status         (div_status),
      .div_remainder      (div_remainder),
      .div_quotient       (div_quotient),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_play_frame     (rsp_play_frame),
      .rsp_beat_index     (rsp_beat_index),
      .rsp_wait_frame     (rsp_wait_frame),
      .rsp_on_bar         (rsp_on_bar),
      .rsp_on_beat        (rsp_on_beat),
      .rsp_on_first_beat  (rsp_on_first_beat),
      .rsp_quantum_passed (rsp_quantum_passed)
   );

   // shared divider
   ltfc_divider #(
      .FRAME_BITS (FRAME_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_status),
      .remainder (div_remainder),
      .quotient  (div_quotient)
   );

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the loop transport frame counter
// drives advance and rewind transfers under random idling on both channels,
// rewrites the registers between phases and compares every result against the
// directed table's status or a cycle-free model of the transport counters and flags
// ----------------------------------------------------------------------------
module testbench;

   localparam int FRAME_W = ltfc_pkg::FRAME_BITS_DEFAULT;
   localparam int BEAT_W  = ltfc_pkg::BEAT_BITS;
   localparam int INDEX_W = ltfc_pkg::CSR_INDEX_BITS;
   localparam int MODE_W  = ltfc_pkg::MODE_BITS;
   // slowest command on the shared divider plus some slack
   localparam int ADVANCE_CYCLES = 4 * ((FRAME_W + 2) / 2 + 2) + 3;
   localparam int RANDOM_PHASES = 17;
   localparam int PHASE_ITEMS = 100;
   localparam longint TIMEOUT_TICKS = 64'd10_000_000;

   typedef struct packed {
      logic [FRAME_W-1:0] play_frame;
      logic [BEAT_W-1:0]  beat_index;
      logic [FRAME_W-1:0] wait_frame;
      logic               on_bar;
      logic               on_beat;
      logic               on_first_beat;
      logic               quantum_passed;
   } transport_status_type;

   typedef struct packed {
      logic                 is_write;
      logic [INDEX_W-1:0]   reg_index;
      logic                 opcode;
      logic [FRAME_W-1:0]   value;
      logic                 typed;
      transport_status_type want;
   } script_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wen = 1'b0;
   logic [INDEX_W-1:0]   csr_index = '0;
   logic [FRAME_W-1:0]   csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_opcode = ltfc_pkg::OP_ADVANCE;
   logic [FRAME_W-1:0]   req_frame_count = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [FRAME_W-1:0]   rsp_play_frame;
   logic [BEAT_W-1:0]    rsp_beat_index;
   logic [FRAME_W-1:0]   rsp_wait_frame;
   logic                 rsp_on_bar;
   logic                 rsp_on_beat;
   logic                 rsp_on_first_beat;
   logic                 rsp_quantum_passed;

   // mirrored registers and counters of the transport
   logic [FRAME_W-1:0]   cfg_loop = FRAME_W'(1);
   logic [FRAME_W-1:0]   cfg_beat = FRAME_W'(1);
   logic [FRAME_W-1:0]   cfg_bar = FRAME_W'(1);
   logic [FRAME_W-1:0]   cfg_quantum = FRAME_W'(1);
   logic                 cfg_quantize = 1'b0;
   logic [MODE_W-1:0]    cfg_mode = ltfc_pkg::MODE_STOPPED;
   logic [FRAME_W-1:0]   play_pos = '0;
   logic [BEAT_W-1:0]    beat_num = '0;
   logic [FRAME_W-1:0]   wait_pos = '0;

   transport_status_type status_due[$];
   script_row_type       script[$];
   logic                 idle_off = 1'b0;
   int unsigned          stall_left = 0;
   int unsigned          error_count = 0;
   int unsigned          sent_count = 0;
   int unsigned          rewind_count = 0;
   int unsigned          setting_count = 0;
   int unsigned          bar_hits = 0;
   int unsigned          beat_hits = 0;
   int unsigned          first_hits = 0;
   int unsigned          quantum_hits = 0;

   loop_transport_frame_counter #(
      .FRAME_BITS(FRAME_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_frame_count(req_frame_count),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_play_frame(rsp_play_frame),
      .rsp_beat_index(rsp_beat_index),
      .rsp_wait_frame(rsp_wait_frame),
      .rsp_on_bar(rsp_on_bar),
      .rsp_on_beat(rsp_on_beat),
      .rsp_on_first_beat(rsp_on_first_beat),
      .rsp_quantum_passed(rsp_quantum_passed)
   );

   always #5 clock = ~clock;

   // a length register written as zero behaves as one
   function automatic longint unsigned at_least_one(input logic [FRAME_W-1:0] len);
      return (len == '0) ? 64'd1 : 64'(len);
   endfunction

   // update the counters for one transfer and return the reported status
   function automatic transport_status_type step_transport(input logic op,
                                                           input logic [FRAME_W-1:0] frames);
      logic                 waiting;
      longint unsigned      loop_len;
      longint unsigned      beat_len;
      longint unsigned      bar_len;
      longint unsigned      quantum_len;
      longint unsigned      sum;
      longint unsigned      quo;
      longint unsigned      active;
      transport_status_type s;
      waiting = (cfg_mode == ltfc_pkg::MODE_WAITING);
      loop_len = at_least_one(cfg_loop);
      beat_len = at_least_one(cfg_beat);
      bar_len = at_least_one(cfg_bar);
      quantum_len = at_least_one(cfg_quantum);
      if (op == ltfc_pkg::OP_REWIND) begin
         play_pos = '0;
         beat_num = '0;
         wait_pos = '0;
      end else if (waiting) begin
         sum = 64'(wait_pos) + 64'(frames);
         wait_pos = FRAME_W'(sum % loop_len);
      end else begin
         sum = 64'(play_pos) + 64'(frames);
         play_pos = FRAME_W'(sum % loop_len);
         quo = 64'(play_pos) / beat_len;
         beat_num = (quo > 64'(ltfc_pkg::BEAT_MAX)) ? ltfc_pkg::BEAT_MAX : BEAT_W'(quo);
      end
      active = waiting ? 64'(wait_pos) : 64'(play_pos);
      s.play_frame = play_pos;
      s.beat_index = beat_num;
      s.wait_frame = wait_pos;
      s.on_bar = !waiting && play_pos != '0 && (64'(play_pos) % bar_len) == 0;
      s.on_beat = (active % beat_len) == 0;
      s.on_first_beat = (play_pos == '0);
      s.quantum_passed = cfg_quantize && (64'(play_pos) % quantum_len) == 0;
      return s;
   endfunction

   // directed table rows
   function automatic script_row_type reg_row(input logic [INDEX_W-1:0] idx,
                                              input logic [FRAME_W-1:0] value);
      script_row_type r;
      r = '0;
      r.is_write = 1'b1;
      r.reg_index = idx;
      r.value = value;
      return r;
   endfunction

   function automatic script_row_type item_row(input logic op,
                                               input logic [FRAME_W-1:0] frames);
      script_row_type r;
      r = '0;
      r.opcode = op;
      r.value = frames;
      return r;
   endfunction

   function automatic script_row_type typed_row(input logic op,
                                                input logic [FRAME_W-1:0] frames,
                                                input logic [FRAME_W-1:0] play,
                                                input logic [BEAT_W-1:0] beat,
                                                input logic [FRAME_W-1:0] waitf,
                                                input logic [3:0] flags);
      script_row_type r;
      r = item_row(op, frames);
      r.typed = 1'b1;
      r.want.play_frame = play;
      r.want.beat_index = beat;
      r.want.wait_frame = waitf;
      {r.want.on_bar, r.want.on_beat, r.want.on_first_beat, r.want.quantum_passed} = flags;
      return r;
   endfunction

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // random register values, biased toward short lengths and the extremes
   function automatic logic [FRAME_W-1:0] pick_length();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return FRAME_W'(1);
         3, 4: return FRAME_W'($urandom);
         default: return FRAME_W'($urandom_range(2, 40));
      endcase
   endfunction

   // random advance amounts, many of them landing on beat and bar boundaries
   function automatic logic [FRAME_W-1:0] pick_advance();
      longint unsigned beat_len;
      longint unsigned bar_len;
      longint unsigned loop_len;
      beat_len = at_least_one(cfg_beat);
      bar_len = at_least_one(cfg_bar);
      loop_len = at_least_one(cfg_loop);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return FRAME_W'($urandom);
         4, 5, 6: return FRAME_W'(beat_len * $urandom_range(1, 4));
         7: return FRAME_W'(bar_len * $urandom_range(1, 2));
         8: return FRAME_W'($urandom_range(0, 63));
         default: return FRAME_W'(loop_len - $urandom_range(1, 3));
      endcase
   endfunction

   // let every transfer in flight come back, with valid low
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_register(input logic [INDEX_W-1:0] idx,
                                 input logic [FRAME_W-1:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (idx)
         ltfc_pkg::REG_LOOP_FRAMES:     cfg_loop = value;
         ltfc_pkg::REG_BEAT_FRAMES:     cfg_beat = value;
         ltfc_pkg::REG_BAR_FRAMES:      cfg_bar = value;
         ltfc_pkg::REG_QUANTUM_FRAMES:  cfg_quantum = value;
         ltfc_pkg::REG_QUANTIZE_ENABLE: cfg_quantize = value[0];
         ltfc_pkg::REG_TRANSPORT_MODE:  cfg_mode = value[MODE_W-1:0];
         default: ;
      endcase
   endtask

   // one request transfer, with an optional gap in front of it
   task automatic send_transfer(input logic op, input logic [FRAME_W-1:0] frames,
                                input logic typed, input transport_status_type want);
      transport_status_type predicted;
      @(negedge clock);
      if (!idle_off && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_frame_count <= frames;
      do @(posedge clock); while (req_stall);
      predicted = step_transport(op, frames);
      status_due.push_back(typed ? want : predicted);
      sent_count++;
      if (op == ltfc_pkg::OP_REWIND) rewind_count++;
   endtask

   // result side back-pressure in bursts
   always @(negedge clock) begin
      if (reset || idle_off) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each result transfer with the oldest expected status
   always @(posedge clock) begin
      transport_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_due.size() == 0) begin
            $error("result transfer with no request outstanding");
            error_count++;
         end else begin
            want = status_due.pop_front();
            check_field("play_frame", 64'(want.play_frame), 64'(rsp_play_frame));
            check_field("beat_index", 64'(want.beat_index), 64'(rsp_beat_index));
            check_field("wait_frame", 64'(want.wait_frame), 64'(rsp_wait_frame));
            check_field("on_bar", 64'(want.on_bar), 64'(rsp_on_bar));
            check_field("on_beat", 64'(want.on_beat), 64'(rsp_on_beat));
            check_field("on_first_beat", 64'(want.on_first_beat), 64'(rsp_on_first_beat));
            check_field("quantum_passed", 64'(want.quantum_passed),
                        64'(rsp_quantum_passed));
            bar_hits += 32'(rsp_on_bar);
            beat_hits += 32'(rsp_on_beat);
            first_hits += 32'(rsp_on_first_beat);
            quantum_hits += 32'(rsp_quantum_passed);
         end
      end
   end

   // hard stop if the block hangs
   initial begin
      #(TIMEOUT_TICKS);
      $display("FAIL loop_transport_frame_counter");
      $finish;
   end

   initial begin
      transport_status_type none;
      logic                 op;
      none = '0;

      // directed table: flags are {on_bar, on_beat, on_first_beat, quantum_passed}
      // reset values, loop of one frame
      script.push_back(typed_row(ltfc_pkg::OP_ADVANCE, '0, '0, '0, '0, 4'b0110));
      script.push_back(typed_row(ltfc_pkg::OP_ADVANCE, '1, '0, '0, '0, 4'b0110));
      // longest loop, one-frame beat, bar and quantum; beat overflow
      script.push_back(reg_row(ltfc_pkg::REG_LOOP_FRAMES, '1));
      script.push_back(reg_row(ltfc_pkg::REG_QUANTIZE_ENABLE, FRAME_W'(1)));
      script.push_back(typed_row(ltfc_pkg::OP_ADVANCE, '1, '0, '0, '0, 4'b0111));
      script.push_back(typed_row(ltfc_pkg::OP_ADVANCE, FRAME_W'(26'h3FFFFFE),
                                 FRAME_W'(26'h3FFFFFE), ltfc_pkg::BEAT_MAX, '0, 4'b1101));
      script.push_back(typed_row(ltfc_pkg::OP_REWIND, '1, '0, '0, '0, 4'b0111));
      // short loop, running
      script.push_back(reg_row(ltfc_pkg::REG_LOOP_FRAMES, FRAME_W'(64)));
      script.push_back(reg_row(ltfc_pkg::REG_BEAT_FRAMES, FRAME_W'(4)));
      script.push_back(reg_row(ltfc_pkg::REG_BAR_FRAMES, FRAME_W'(16)));
      script.push_back(reg_row(ltfc_pkg::REG_QUANTUM_FRAMES, FRAME_W'(8)));
      script.push_back(reg_row(ltfc_pkg::REG_TRANSPORT_MODE,
                               FRAME_W'(ltfc_pkg::MODE_RUNNING)));
      script.push_back(item_row(ltfc_pkg::OP_ADVANCE, FRAME_W'(4)));
      script.push_back(item_row(ltfc_pkg::OP_ADVANCE, FRAME_W'(4)));
      script.push_back(item_row(ltfc_pkg::OP_ADVANCE, FRAME_W'(8)));
      script.push_back(item_row(ltfc_pkg::OP_ADVANCE, FRAME_W'(50)));
      // waiting for start, then the unused mode
      script.push_back(reg_row(ltfc_pkg::REG_TRANSPORT_MODE,
                               FRAME_W'(ltfc_pkg::MODE_WAITING)));
      script.push_back(item_row(ltfc_pkg::OP_ADVANCE, FRAME_W'(3)));
      script.push_back(item_row(ltfc_pkg::OP_ADVANCE, FRAME_W'(61)));
      script.push_back(item_row(ltfc_pkg::OP_REWIND, '0));
      script.push_back(reg_row(ltfc_pkg::REG_TRANSPORT_MODE, FRAME_W'(3)));
      script.push_back(item_row(ltfc_pkg::OP_ADVANCE, FRAME_W'(20)));
      // zero lengths act as one, stopped mode still advances
      script.push_back(reg_row(ltfc_pkg::REG_TRANSPORT_MODE,
                               FRAME_W'(ltfc_pkg::MODE_STOPPED)));
      script.push_back(reg_row(ltfc_pkg::REG_LOOP_FRAMES, '0));
      script.push_back(reg_row(ltfc_pkg::REG_BEAT_FRAMES, '0));
      script.push_back(reg_row(ltfc_pkg::REG_BAR_FRAMES, '0));
      script.push_back(reg_row(ltfc_pkg::REG_QUANTUM_FRAMES, '0));
      script.push_back(typed_row(ltfc_pkg::OP_ADVANCE, FRAME_W'(12345), '0, '0, '0,
                                 4'b0111));
      // loop shortened under a counter, wrapped by the next advance in running mode
      script.push_back(reg_row(ltfc_pkg::REG_LOOP_FRAMES, FRAME_W'(1000)));
      script.push_back(reg_row(ltfc_pkg::REG_BEAT_FRAMES, FRAME_W'(10)));
      script.push_back(reg_row(ltfc_pkg::REG_BAR_FRAMES, FRAME_W'(100)));
      script.push_back(reg_row(ltfc_pkg::REG_QUANTUM_FRAMES, FRAME_W'(25)));
      script.push_back(reg_row(ltfc_pkg::REG_TRANSPORT_MODE,
                               FRAME_W'(ltfc_pkg::MODE_RUNNING)));
      script.push_back(item_row(ltfc_pkg::OP_ADVANCE, FRAME_W'(900)));
      script.push_back(reg_row(ltfc_pkg::REG_LOOP_FRAMES, FRAME_W'(100)));
      script.push_back(reg_row(ltfc_pkg::REG_TRANSPORT_MODE,
                               FRAME_W'(ltfc_pkg::MODE_WAITING)));
      script.push_back(item_row(ltfc_pkg::OP_ADVANCE, FRAME_W'(5)));
      script.push_back(reg_row(ltfc_pkg::REG_TRANSPORT_MODE,
                               FRAME_W'(ltfc_pkg::MODE_RUNNING)));
      script.push_back(item_row(ltfc_pkg::OP_ADVANCE, FRAME_W'(1)));
      // beat saturation on a mid-size loop, quantizer off
      script.push_back(reg_row(ltfc_pkg::REG_BEAT_FRAMES, FRAME_W'(1)));
      script.push_back(reg_row(ltfc_pkg::REG_LOOP_FRAMES, FRAME_W'(5000)));
      script.push_back(item_row(ltfc_pkg::OP_ADVANCE, FRAME_W'(4000)));
      script.push_back(reg_row(ltfc_pkg::REG_QUANTIZE_ENABLE, '0));
      script.push_back(item_row(ltfc_pkg::OP_ADVANCE, FRAME_W'(3000)));
      script.push_back(typed_row(ltfc_pkg::OP_REWIND, '0, '0, '0, '0, 4'b0110));

      // hold reset, then release it
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (script[i]) begin
         if (script[i].is_write) begin
            settle_idle();
            write_register(script[i].reg_index, script[i].value);
         end else begin
            send_transfer(script[i].opcode, script[i].value, script[i].typed, script[i].want);
         end
      end
      setting_count = 8;

      // random phases, each with its own register setting
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_idle();
         idle_off = (phase == RANDOM_PHASES - 1) || ($urandom_range(0, 4) == 0);
         write_register(ltfc_pkg::REG_LOOP_FRAMES, pick_length());
         write_register(ltfc_pkg::REG_BEAT_FRAMES, pick_length());
         if ($urandom_range(0, 1) == 0)
            write_register(ltfc_pkg::REG_BAR_FRAMES, FRAME_W'(at_least_one(cfg_beat) *
                                                              $urandom_range(1, 4)));
         else
            write_register(ltfc_pkg::REG_BAR_FRAMES, pick_length());
         write_register(ltfc_pkg::REG_QUANTUM_FRAMES, pick_length());
         write_register(ltfc_pkg::REG_QUANTIZE_ENABLE, FRAME_W'($urandom));
         write_register(ltfc_pkg::REG_TRANSPORT_MODE, FRAME_W'($urandom));
         setting_count++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // now and then hold off until the block has drained
            if ($urandom_range(0, 99) == 0) settle_idle();
            op = ($urandom_range(0, 19) == 0) ? ltfc_pkg::OP_REWIND : ltfc_pkg::OP_ADVANCE;
            send_transfer(op, (op == ltfc_pkg::OP_REWIND) ? FRAME_W'($urandom) : pick_advance(),
                          1'b0, none);
         end
      end

      // drain and watch for stray results
      @(negedge clock);
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (ADVANCE_CYCLES + 8) @(posedge clock);

      $display("covered %0d transfers (%0d rewinds) over %0d register settings",
               sent_count, rewind_count, setting_count);
      $display("flags raised: bar %0d, beat %0d, first beat %0d, quantum %0d",
               bar_hits, beat_hits, first_hits, quantum_hits);
      if (error_count == 0)
         $display("PASS loop_transport_frame_counter");
      else
         $display("FAIL loop_transport_frame_counter");
      $finish;
   end

endmodule

[loop_transport_frame_counter.f]
rtl/ltfc_pkg.sv
rtl/ltfc_front.sv
rtl/ltfc_queue.sv
rtl/ltfc_divider.sv
rtl/ltfc_back.sv
rtl/loop_transport_frame_counter.sv
tb/sv/testbench.sv
